FILE: src/sfe_pkg.sv
`default_nettype none

package sfe_pkg;

    // one input item
    typedef struct packed {
        logic        kind;
        logic [31:0] frame_id;
        logic [15:0] frame_type;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_last;
    } t_out_item;

    // byte index within the burst one item causes
    typedef logic [3:0] t_idx;

    // item kinds
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // burst layout
    localparam t_idx HDR_LAST_IDX = 4'd11;  // last header byte
    localparam t_idx HDR_CKS_IDX  = 4'd12;  // checksum after an empty frame
    localparam t_idx PAY_DATA_IDX = 4'd0;
    localparam t_idx PAY_CKS_IDX  = 4'd1;

    // frame start marker, sent first
    localparam logic [7:0] MAGIC [4] = '{8'h53, 8'h54, 8'h52, 8'h58};

    // work handed from the frame control to the byte sequencer
    typedef struct packed {
        logic        hdr;
        logic [31:0] frame_id;
        logic [15:0] frame_type;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
        logic [7:0]  cks;        // plain checksum, mask applied on the way out
        t_idx        last_idx;
    } t_job;

endpackage

`default_nettype wire

FILE: src/sfe_frame_ctl.sv
`default_nettype none

module sfe_frame_ctl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire sfe_pkg::t_in_item i_item,
    output logic                   o_job_valid,
    output sfe_pkg::t_job          o_job
);

    logic [15:0] r_remain, n_remain;
    logic [7:0]  r_cks, n_cks;
    logic        r_open, n_open;
    logic [15:0] w_rem_dec;
    logic [7:0]  w_cks_fold;

    assign w_rem_dec  = r_remain - 16'd1;
    assign w_cks_fold = r_cks ^ i_item.data_byte;

    // frame state update and burst description for the accepted item
    always_comb begin
        n_remain    = r_remain;
        n_cks       = r_cks;
        n_open      = r_open;
        o_job_valid = 1'b0;
        o_job.hdr            = (i_item.kind == sfe_pkg::KIND_HEADER);
        o_job.frame_id       = i_item.frame_id;
        o_job.frame_type     = i_item.frame_type;
        o_job.payload_length = i_item.payload_length;
        o_job.data_byte      = i_item.data_byte;
        o_job.cks            = '0;
        o_job.last_idx       = sfe_pkg::PAY_DATA_IDX;
        if (i_item.kind == sfe_pkg::KIND_HEADER) begin
            o_job_valid = 1'b1;
            n_cks       = '0;
            if (i_item.payload_length == 16'd0) begin
                o_job.last_idx = sfe_pkg::HDR_CKS_IDX;
                n_remain       = '0;
                n_open         = 1'b0;
            end else begin
                o_job.last_idx = sfe_pkg::HDR_LAST_IDX;
                n_remain       = i_item.payload_length;
                n_open         = 1'b1;
            end
        end else if (r_open) begin
            o_job_valid = 1'b1;
            n_remain    = w_rem_dec;
            o_job.cks   = w_cks_fold;
            if (w_rem_dec == 16'd0) begin
                o_job.last_idx = sfe_pkg::PAY_CKS_IDX;
                n_open         = 1'b0;
                n_cks          = '0;
            end else begin
                n_cks = w_cks_fold;
            end
        end
    end

    // state registers, updated on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remain <= '0;
            r_cks    <= '0;
            r_open   <= 1'b0;
        end else if (i_accept) begin
            r_remain <= n_remain;
            r_cks    <= n_cks;
            r_open   <= n_open;
        end
    end

endmodule

`default_nettype wire

FILE: src/sfe_byte_seq.sv
`default_nettype none

module sfe_byte_seq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [7:0]         i_mask,
    input  wire logic               i_load,
    input  wire logic               i_job_valid,
    input  wire sfe_pkg::t_job      i_job,
    output logic                    o_take,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output sfe_pkg::t_out_item      o_item
);

    logic               r_job_valid;
    sfe_pkg::t_job      r_job;
    sfe_pkg::t_idx      r_idx;
    logic               r_out_valid;
    sfe_pkg::t_out_item r_out;
    logic               w_out_adv;
    logic               w_at_last;
    logic [7:0]         w_byte;
    logic               w_end;

    assign w_out_adv = !r_out_valid || i_ready;
    assign w_at_last = (r_idx == r_job.last_idx);
    assign o_take    = !r_job_valid || (w_out_adv && w_at_last);
    assign o_valid   = r_out_valid;
    assign o_item    = r_out;

    // byte select for the current burst position
    always_comb begin
        w_byte = '0;
        w_end  = 1'b0;
        if (r_job.hdr) begin
            case (r_idx)
                4'd0, 4'd1, 4'd2, 4'd3: w_byte = sfe_pkg::MAGIC[r_idx[1:0]];
                4'd4:  w_byte = r_job.frame_id[7:0];
                4'd5:  w_byte = r_job.frame_id[15:8];
                4'd6:  w_byte = r_job.frame_id[23:16];
                4'd7:  w_byte = r_job.frame_id[31:24];
                4'd8:  w_byte = r_job.frame_type[7:0];
                4'd9:  w_byte = r_job.frame_type[15:8];
                4'd10: w_byte = r_job.payload_length[7:0];
                4'd11: w_byte = r_job.payload_length[15:8];
                sfe_pkg::HDR_CKS_IDX: begin
                    w_byte = r_job.cks ^ i_mask;
                    w_end  = 1'b1;
                end
                default: w_byte = '0;
            endcase
        end else begin
            case (r_idx)
                sfe_pkg::PAY_DATA_IDX: w_byte = r_job.data_byte ^ i_mask;
                sfe_pkg::PAY_CKS_IDX: begin
                    w_byte = r_job.cks ^ i_mask;
                    w_end  = 1'b1;
                end
                default: w_byte = '0;
            endcase
        end
    end

    // burst register: loaded on input transfer, stepped as bytes leave
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= '0;
        end else if (i_load) begin
            r_job_valid <= i_job_valid;
            r_idx       <= '0;
        end else if (r_job_valid && w_out_adv) begin
            r_idx <= r_idx + 4'd1;
            if (w_at_last) begin
                r_job_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv && r_job_valid) begin
            r_out.out_byte  <= w_byte;
            r_out.frame_end <= w_end;
            r_out.run_last  <= w_at_last;
        end
    end

`ifndef SYNTHESIS
    // burst position never runs past its last byte
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_idx <= r_job.last_idx))
        else $error("burst index past last byte");

    // a checksum byte always closes the burst of its item
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_end) |-> r_out.run_last)
        else $error("checksum byte not last of burst");

    // a new item is only taken once the current burst is fully handed on
    a_take_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && r_job_valid) |-> (w_at_last && w_out_adv))
        else $error("burst overwritten before done");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

FILE: src/scrambled_frame_encoder_core.sv
// channel   | valid   | ready   | payload
// ----------+---------+---------+-------------------------------
// input     | i_valid | o_ready | i_item (sfe_pkg::t_in_item)
// output    | o_valid | i_ready | o_item (sfe_pkg::t_out_item)
// config    | i_cfg_we| -       | i_cfg_data (scramble mask)
//
// one result byte leaves per cycle while the output is not stalled; a payload item
// gives one byte, or two when it closes the frame, a header item gives 12 bytes,
// or 13 for an empty frame; the byte sequencer sends them through the output register.
// a payload item that finds no open frame is taken and gives nothing.
// reset is synchronous, active low; it closes any frame and sets the mask to 0x55.
// a stall on the output holds the result and backs up into o_ready.
`default_nettype none

module scrambled_frame_encoder_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire sfe_pkg::t_in_item  i_item,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output sfe_pkg::t_out_item      o_item,
    input  wire logic               i_cfg_we,
    input  wire logic [7:0]         i_cfg_data
);

    logic [7:0]    r_scramble_mask;
    logic          w_in_acc;
    logic          w_job_valid;
    sfe_pkg::t_job w_job;

    assign w_in_acc = i_valid && o_ready;

    // scramble mask register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scramble_mask <= 8'h55;
        end else if (i_cfg_we) begin
            r_scramble_mask <= i_cfg_data;
        end
    end

    // frame state and burst description
    sfe_frame_ctl u_frame_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_in_acc),
        .i_item      (i_item),
        .o_job_valid (w_job_valid),
        .o_job       (w_job)
    );

    // byte sequencing and output register
    sfe_byte_seq u_byte_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mask      (r_scramble_mask),
        .i_load      (w_in_acc),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_take      (o_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

`ifndef SYNTHESIS
    // the mask holds its value unless a config write happened
    a_mask_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(i_cfg_we) && $past(i_rst_n)) |-> $stable(r_scramble_mask))
        else $error("mask changed without a write");

    // a written mask reflects the written data
    a_mask_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_scramble_mask == $past(i_cfg_data)))
        else $error("mask write lost");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");
`endif

endmodule

`default_nettype wire
